/* rtl/pixel_run_length_packet_encoder_top_defines.svh */
// Assertion macros for the packet encoder.
`ifndef PIXEL_RUN_LENGTH_PACKET_ENCODER_TOP_DEFINES_SVH
`define PIXEL_RUN_LENGTH_PACKET_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PRLE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prle assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define PRLE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prle assertion failed");

`endif

/* rtl/prle_pkg.sv */
package prle_pkg;

    localparam int PX_W   = 32;
    localparam int HDR_W  = 8;
    localparam int CNT_W  = 8;
    localparam int BPP_W  = 3;
    localparam int LANES  = 4;
    localparam int LANE_W = 2;
    localparam int PCNT_W = 3;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
    localparam logic [HDR_W-1:0] RUN_FLAG  = 8'h80;

    typedef enum logic [1:0] {
        PKT_NONE,
        PKT_RAW,
        PKT_SINGLE
    } pkt_kind_t;

    // One packet: raw packets read ram_cnt pixels from a bank, plus an optional tail.
    typedef struct packed {
        pkt_kind_t          kind;
        logic               bank;
        logic [CNT_W-1:0]   ram_cnt;
        logic               tail_en;
        logic [PX_W-1:0]    px;
        logic [HDR_W-1:0]   hdr;
    } pkt_t;

    typedef struct packed {
        pkt_t p0;
        pkt_t p1;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    typedef struct packed {
        logic [1:0] busy;
        logic       cur;
    } bank_st_t;

    typedef struct packed {
        logic               has_hdr;
        logic [HDR_W-1:0]   hdr;
        logic [PCNT_W-1:0]  cnt;
        logic [LANES-1:0]   ram_mask;
        logic [PX_W-1:0]    px;
        logic               last;
    } item_desc_t;

    function automatic pkt_t mk_single(input logic [PX_W-1:0] px,
                                       input logic [HDR_W-1:0] hdr);
        pkt_t p;
        p      = '0;
        p.kind = PKT_SINGLE;
        p.px   = px;
        p.hdr  = hdr;
        return p;
    endfunction

    function automatic pkt_t mk_raw(input logic bank, input logic [CNT_W-1:0] cnt,
                                    input logic tail_en, input logic [PX_W-1:0] px);
        pkt_t             p;
        logic [CNT_W-1:0] n;
        n         = cnt + CNT_W'(tail_en);
        p         = '0;
        p.kind    = PKT_RAW;
        p.bank    = bank;
        p.ram_cnt = cnt;
        p.tail_en = tail_en;
        p.px      = px;
        p.hdr     = (n - CNT_W'(1)) & ~RUN_FLAG;
        return p;
    endfunction

    function automatic logic [HDR_W-1:0] run_hdr(input logic [CNT_W-1:0] len_m1);
        return RUN_FLAG | (len_m1 & ~RUN_FLAG);
    endfunction

endpackage

/* rtl/prle_ram.sv */
module prle_ram import prle_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/prle_front.sv */
module prle_front import prle_pkg::*; #(
    parameter int MAX_PACKET = 128,
    parameter int ROW_W      = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    bpp_we,
    input  logic [BPP_W-1:0]        bytes_per_pixel,
    input  logic                    acc,
    input  logic [PX_W-1:0]         pixel,
    input  logic                    line_end,
    input  rel_t                    rel,
    output logic                    push,
    output cmd_t                    cmd,
    output logic [LANES-1:0]        wr_en,
    output logic [ROW_W:0]          wr_addr,
    output logic [PX_W-1:0]         wr_data,
    output bank_st_t                bst
);

    localparam logic [CNT_W:0] MAX_C = (CNT_W+1)'(MAX_PACKET);

    logic [BPP_W-1:0] bpp_reg;
    logic [PX_W-1:0]  prev_reg,    prev_next;
    logic             started_reg, started_next;
    logic [CNT_W-1:0] rep_reg,     rep_next;
    logic [CNT_W-1:0] pend_reg,    pend_next;
    logic             cur_reg,     cur_next;
    logic [1:0]       busy_reg,    busy_next;

    logic [PX_W-1:0]  mask;
    logic [PX_W-1:0]  p;
    logic             flush_raw;
    logic             switch_bank;
    logic             wr;
    logic [CNT_W-1:0] pend1;
    logic [CNT_W-1:0] rep1;
    pkt_t             run_pkt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg     <= BPP_RESET;
            prev_reg    <= '0;
            started_reg <= 1'b0;
            rep_reg     <= '0;
            pend_reg    <= '0;
            cur_reg     <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            if (bpp_we)
            begin
                bpp_reg <= bytes_per_pixel;
            end
            prev_reg    <= prev_next;
            started_reg <= started_next;
            rep_reg     <= rep_next;
            pend_reg    <= pend_next;
            cur_reg     <= cur_next;
            busy_reg    <= busy_next;
        end
    end

    always_comb
    begin
        unique case (bpp_reg)
            3'd0, 3'd1: mask = 32'h0000_00FF;
            3'd2:       mask = 32'h0000_FFFF;
            3'd3:       mask = 32'h00FF_FFFF;
            default:    mask = 32'hFFFF_FFFF;
        endcase
    end

    assign p     = pixel & mask;
    assign pend1 = pend_reg + CNT_W'(1);
    assign rep1  = rep_reg + CNT_W'(1);

    always_comb
    begin
        prev_next    = prev_reg;
        started_next = started_reg;
        rep_next     = rep_reg;
        pend_next    = pend_reg;
        cmd.p0       = '0;
        cmd.p1       = '0;
        cmd.p0.kind  = PKT_NONE;
        cmd.p1.kind  = PKT_NONE;
        flush_raw    = 1'b0;
        switch_bank  = 1'b0;
        wr           = 1'b0;
        run_pkt      = mk_single(prev_reg, run_hdr(rep1));

        if (acc)
        begin
            if (!started_reg)
            begin
                prev_next    = p;
                started_next = 1'b1;
                rep_next     = '0;
                pend_next    = '0;
                if (line_end)
                begin
                    cmd.p0 = mk_single(p, '0);
                end
            end
            else if (p == prev_reg)
            begin
                flush_raw = (rep_reg == '0) && (pend_reg != '0);
                if (flush_raw)
                begin
                    cmd.p0      = mk_raw(cur_reg, pend_reg, 1'b0, '0);
                    switch_bank = 1'b1;
                    pend_next   = '0;
                end
                // full run or line end closes the run now
                if (({1'b0, rep_reg} + (CNT_W+1)'(2) >= MAX_C) || line_end)
                begin
                    if (flush_raw)
                    begin
                        cmd.p1 = run_pkt;
                    end
                    else
                    begin
                        cmd.p0 = run_pkt;
                    end
                    rep_next     = '0;
                    started_next = 1'b0;
                end
                else
                begin
                    rep_next = rep1;
                end
            end
            else
            begin
                if (rep_reg != '0)
                begin
                    cmd.p0   = mk_single(prev_reg, run_hdr(rep_reg));
                    rep_next = '0;
                    if (line_end)
                    begin
                        cmd.p1 = mk_single(p, '0);
                    end
                end
                else
                begin
                    wr = 1'b1;
                    if ({1'b0, pend1} >= MAX_C)
                    begin
                        cmd.p0      = mk_raw(cur_reg, pend1, 1'b0, '0);
                        switch_bank = 1'b1;
                        pend_next   = '0;
                        if (line_end)
                        begin
                            cmd.p1 = mk_single(p, '0);
                        end
                    end
                    else if (line_end)
                    begin
                        cmd.p0      = mk_raw(cur_reg, pend1, 1'b1, p);
                        switch_bank = 1'b1;
                    end
                    else
                    begin
                        pend_next = pend1;
                    end
                end
                prev_next = p;
            end

            if (line_end)
            begin
                started_next = 1'b0;
                rep_next     = '0;
                pend_next    = '0;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cur_next  = cur_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (switch_bank)
        begin
            busy_next[cur_reg] = 1'b1;
            cur_next           = ~cur_reg;
        end
    end

    always_comb
    begin
        wr_en = '0;
        if (wr)
        begin
            wr_en[pend_reg[LANE_W-1:0]] = 1'b1;
        end
    end

    assign wr_addr  = {cur_reg, ROW_W'(pend_reg >> LANE_W)};
    assign wr_data  = prev_reg;
    assign push     = acc && (cmd.p0.kind != PKT_NONE);
    assign bst.busy = busy_reg;
    assign bst.cur  = cur_reg;

endmodule

/* rtl/prle_queue.sv */
module prle_queue import prle_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    output logic valid,
    output cmd_t head,
    input  logic pop
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] head_reg,  head_next;
    logic [QPTR_W-1:0] tail_reg,  tail_next;
    logic [QPTR_W:0]   count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = tail_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            head_next = head_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[head_reg];

endmodule

/* rtl/prle_back.sv */
module prle_back import prle_pkg::*; #(
    parameter int ROW_W = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  cmd_t                        cmd,
    output logic                        q_pop,
    output logic                        re,
    output logic [ROW_W:0]              raddr,
    input  logic [LANES-1:0][PX_W-1:0]  rdata,
    output rel_t                        rel,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        has_header,
    output logic [HDR_W-1:0]            header_byte,
    output logic [PCNT_W-1:0]           pixel_count,
    output logic [LANES-1:0][PX_W-1:0]  lanes,
    output logic                        last_of_run
);

    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] done_reg,  done_next;
    logic             s2_valid_reg, s2_valid_next;
    item_desc_t       s2_reg;
    logic             out_valid_reg, out_valid_next;
    logic             hdr_flag_reg;
    logic [HDR_W-1:0] hdr_reg;
    logic [PCNT_W-1:0] cnt_reg;
    logic [LANES-1:0][PX_W-1:0] lanes_reg;
    logic             last_reg;

    pkt_t             pk;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] rem;
    logic             pkt_last;
    logic             entry_last;
    item_desc_t       desc;
    logic             out_ready;
    logic             s2_adv;
    logic             issue;
    logic [LANES-1:0][PX_W-1:0] asm_lanes;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_adv    = s2_valid_reg && out_ready;
    assign issue     = q_valid && (!s2_valid_reg || s2_adv);

    always_comb
    begin
        pk  = phase_reg ? cmd.p1 : cmd.p0;
        n   = pk.ram_cnt + CNT_W'(pk.tail_en);
        rem = n - done_reg;
        desc          = '0;
        desc.px       = pk.px;
        desc.hdr      = pk.hdr;
        pkt_last      = 1'b1;
        if (pk.kind == PKT_RAW)
        begin
            desc.has_hdr = (done_reg == '0);
            if (rem > CNT_W'(LANES))
            begin
                desc.cnt = PCNT_W'(LANES);
                pkt_last = 1'b0;
            end
            else
            begin
                desc.cnt = PCNT_W'(rem);
            end
            for (int j = 0; j < LANES; j++)
            begin
                desc.ram_mask[j] = ({1'b0, done_reg} + (CNT_W+1)'(j)) < {1'b0, pk.ram_cnt};
            end
        end
        else
        begin
            desc.has_hdr = 1'b1;
            desc.cnt     = PCNT_W'(1);
        end
        entry_last = pkt_last && (phase_reg || (cmd.p1.kind == PKT_NONE));
        desc.last  = entry_last;
    end

    assign q_pop     = issue && entry_last;
    assign re        = issue && (pk.kind == PKT_RAW);
    assign raddr     = {pk.bank, ROW_W'(done_reg >> LANE_W)};
    assign rel.valid = re && pkt_last;
    assign rel.bank  = pk.bank;

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = done_reg;
        if (issue)
        begin
            if (entry_last)
            begin
                phase_next = 1'b0;
                done_next  = '0;
            end
            else if (pkt_last)
            begin
                phase_next = 1'b1;
                done_next  = '0;
            end
            else
            begin
                done_next = done_reg + CNT_W'(LANES);
            end
        end
        s2_valid_next = s2_valid_reg;
        if (issue)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = s2_valid_reg;
        end
    end

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            if (PCNT_W'(j) < s2_reg.cnt)
            begin
                asm_lanes[j] = s2_reg.ram_mask[j] ? rdata[j] : s2_reg.px;
            end
            else
            begin
                asm_lanes[j] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            done_reg      <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            done_reg      <= done_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_reg <= desc;
        end
        if (s2_adv)
        begin
            hdr_flag_reg <= s2_reg.has_hdr;
            hdr_reg      <= s2_reg.has_hdr ? s2_reg.hdr : '0;
            cnt_reg      <= s2_reg.cnt;
            lanes_reg    <= asm_lanes;
            last_reg     <= s2_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign has_header  = hdr_flag_reg;
    assign header_byte = hdr_reg;
    assign pixel_count = cnt_reg;
    assign lanes       = lanes_reg;
    assign last_of_run = last_reg;

endmodule

/* rtl/pixel_run_length_packet_encoder_top.sv */
// TGA run-length packet encoder.
// Input channel: in_valid/in_stall carry one pixel and line_end per item.
// Output channel: out_valid/out_stall carry one packet piece per item: an
// optional header byte, 1..4 pixels in lanes 0..3, and last_of_run on the
// final item caused by an input pixel.
// bytes_per_pixel must be written through bpp_we only while the block is
// idle; nothing in the block enforces this. One pixel is accepted per cycle
// while in_stall is low and one item is sent per cycle while out_stall is
// low. Raw pixels go to two banks of RAM, one lane RAM per output lane, so
// an unstalled raw packet drains four pixels per cycle while the other bank
// fills. in_stall rises when the bank that would be filled is still being
// read out, or when the four-entry command queue is full.
// A stalled output holds its item; the queue absorbs commands until full.
// Reset empties the queue and the pipeline, clears the line state and sets
// bytes_per_pixel to 4. No memory clearing pass is needed.
`include "pixel_run_length_packet_encoder_top_defines.svh"

module pixel_run_length_packet_encoder_top import prle_pkg::*; #(
    parameter int MAX_PACKET = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bpp_we,
    input  logic [BPP_W-1:0]  bytes_per_pixel,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PX_W-1:0]   pixel,
    input  logic              line_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              has_header,
    output logic [HDR_W-1:0]  header_byte,
    output logic [PCNT_W-1:0] pixel_count,
    output logic [PX_W-1:0]   pixel_lane0,
    output logic [PX_W-1:0]   pixel_lane1,
    output logic [PX_W-1:0]   pixel_lane2,
    output logic [PX_W-1:0]   pixel_lane3,
    output logic              last_of_run
);

    localparam int ROWS  = (MAX_PACKET + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH = 2 << ROW_W;

    logic                       acc;
    logic                       push;
    cmd_t                       push_cmd;
    logic                       q_full;
    logic                       q_valid;
    cmd_t                       head;
    logic                       q_pop;
    logic [LANES-1:0]           wr_en;
    logic [ROW_W:0]             wr_addr;
    logic [PX_W-1:0]            wr_data;
    logic                       re;
    logic [ROW_W:0]             raddr;
    logic [LANES-1:0][PX_W-1:0] rdata;
    logic [LANES-1:0][PX_W-1:0] lanes;
    rel_t                       rel;
    bank_st_t                   bst;

    assign in_stall = bst.busy[bst.cur] || q_full;
    assign acc      = in_valid && !in_stall;

    prle_front #(
        .MAX_PACKET (MAX_PACKET),
        .ROW_W      (ROW_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .bpp_we          (bpp_we),
        .bytes_per_pixel (bytes_per_pixel),
        .acc             (acc),
        .pixel           (pixel),
        .line_end        (line_end),
        .rel             (rel),
        .push            (push),
        .cmd             (push_cmd),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .bst             (bst)
    );

    prle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .valid     (q_valid),
        .head      (head),
        .pop       (q_pop)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        prle_ram #(
            .WIDTH (PX_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en[g]),
            .waddr (wr_addr),
            .wdata (wr_data),
            .re    (re),
            .raddr (raddr),
            .rdata (rdata[g])
        );
    end

    prle_back #(
        .ROW_W (ROW_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .cmd         (head),
        .q_pop       (q_pop),
        .re          (re),
        .raddr       (raddr),
        .rdata       (rdata),
        .rel         (rel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .has_header  (has_header),
        .header_byte (header_byte),
        .pixel_count (pixel_count),
        .lanes       (lanes),
        .last_of_run (last_of_run)
    );

    assign pixel_lane0 = lanes[0];
    assign pixel_lane1 = lanes[1];
    assign pixel_lane2 = lanes[2];
    assign pixel_lane3 = lanes[3];

    `PRLE_ASSERT_IMP(a_rel_busy, rel.valid, bst.busy[rel.bank])
    `PRLE_ASSERT_NEXT(a_rel_frees, rel.valid, !bst.busy[$past(rel.bank)])
    `PRLE_ASSERT_IMP(a_hdr_zero, out_valid && !has_header, header_byte == '0)
    `PRLE_ASSERT_IMP(a_run_one, out_valid && has_header && header_byte[7], pixel_count == PCNT_W'(1))

endmodule
